// ----- rtl/pzfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pzfr_pkg - shared types and constants for the pixel zoom/flip/rotate core
// Register map, field widths, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package pzfr_pkg;

  // Fixed field widths
  localparam int MAG_W      = 5;
  localparam int ORIENT_W   = 3;
  localparam int SRC_DIM_W  = 8;
  localparam int VIEW_DIM_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;

  // Parameter defaults
  localparam int DEF_MAX_SRC_WIDTH  = 128;
  localparam int DEF_MAX_SRC_HEIGHT = 128;
  localparam int DEF_MAX_VIEW       = 1024;
  localparam int DEF_MAX_MAG        = 16;

  // Register reset values
  localparam logic [MAG_W-1:0]      RST_MAG_X       = MAG_W'(2);
  localparam logic [MAG_W-1:0]      RST_MAG_Y       = MAG_W'(2);
  localparam logic [ORIENT_W-1:0]   RST_ORIENTATION = '0;
  localparam logic [SRC_DIM_W-1:0]  RST_SRC_WIDTH   = SRC_DIM_W'(128);
  localparam logic [SRC_DIM_W-1:0]  RST_SRC_HEIGHT  = SRC_DIM_W'(128);
  localparam logic [VIEW_DIM_W-1:0] RST_VIEW_WIDTH  = VIEW_DIM_W'(256);
  localparam logic [VIEW_DIM_W-1:0] RST_VIEW_HEIGHT = VIEW_DIM_W'(256);

  // Orientation bits
  localparam int ORIENT_MIRROR_LR = 0;
  localparam int ORIENT_MIRROR_TB = 1;
  localparam int ORIENT_TRANSPOSE = 2;

  // Word opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAG_X       = 3'd0,
    REG_MAG_Y       = 3'd1,
    REG_ORIENTATION = 3'd2,
    REG_SRC_WIDTH   = 3'd3,
    REG_SRC_HEIGHT  = 3'd4,
    REG_VIEW_WIDTH  = 3'd5,
    REG_VIEW_HEIGHT = 3'd6
  } cfg_reg_t;

  // Register file contents
  typedef struct packed {
    logic [MAG_W-1:0]      mag_x;
    logic [MAG_W-1:0]      mag_y;
    logic [ORIENT_W-1:0]   orientation;
    logic [SRC_DIM_W-1:0]  src_width;
    logic [SRC_DIM_W-1:0]  src_height;
    logic [VIEW_DIM_W-1:0] view_width;
    logic [VIEW_DIM_W-1:0] view_height;
  } cfg_t;

  // Scan strobes from the top level
  typedef struct packed {
    logic restart;
    logic load_go;
    logic emit_go;
  } scan_ctrl_t;

endpackage

// ----- rtl/pzfr_scan.sv -----
// ----------------------------------------------------------------------------
// pzfr_scan - load and emit position counters with address generation
// Tracks the raster load index and the output scan, and forms the frame
// store address of the current output pixel without any division.
// ----------------------------------------------------------------------------
module pzfr_scan #(
  parameter int MAX_SRC_WIDTH  = pzfr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = pzfr_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_VIEW       = pzfr_pkg::DEF_MAX_VIEW,
  parameter int MAX_MAG        = pzfr_pkg::DEF_MAX_MAG,
  localparam int ADDR_W        = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT),
  localparam int POS_W         = $clog2(MAX_VIEW)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pzfr_pkg::cfg_t       cfg,
  input  pzfr_pkg::scan_ctrl_t ctrl,
  output logic [ADDR_W-1:0]    load_addr,
  output logic [ADDR_W-1:0]    rd_addr,
  output logic [POS_W-1:0]     pos_x,
  output logic [POS_W-1:0]     pos_y,
  output logic                 frame_last
);
  import pzfr_pkg::*;

  localparam int SW_W    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DIM_W   = (SW_W > SH_W) ? SW_W : SH_W;
  localparam int MAXS    = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int BLK_W   = $clog2(MAXS);
  localparam int MAG_CW  = $clog2(MAX_MAG + 1);
  localparam int SUB_W   = $clog2(MAX_MAG);
  localparam int VIEW_SW = $clog2(MAX_VIEW + 1);
  localparam int PROD_W  = MAG_CW + DIM_W;
  localparam int EXT_W   = (PROD_W > VIEW_SW) ? PROD_W : VIEW_SW;
  localparam int TOT_W   = SW_W + SH_W;
  localparam int AW2     = DIM_W + SW_W;

  // Position state
  logic [ADDR_W-1:0] load_idx_r, load_idx_nxt;
  logic [POS_W-1:0]  ecol_r, ecol_nxt, erow_r, erow_nxt;
  logic [SUB_W-1:0]  csub_r, csub_nxt, rsub_r, rsub_nxt;
  logic [BLK_W-1:0]  bcol_r, bcol_nxt, brow_r, brow_nxt;

  // Clamped geometry
  logic [MAG_CW-1:0]  mx, my;
  logic [SW_W-1:0]    sw;
  logic [SH_W-1:0]    sh;
  logic [VIEW_SW-1:0] vw, vh, ow, oh;
  logic [DIM_W-1:0]   dim_x, dim_y;
  logic [EXT_W-1:0]   ow_full, oh_full;
  logic [TOT_W-1:0]   total, load_inc;
  logic               mirror_lr, mirror_b, transpose;

  // Emit working values
  logic [POS_W-1:0]  ec, er;
  logic [SUB_W-1:0]  cs, rs;
  logic [BLK_W-1:0]  bcl, brw;
  logic [DIM_W-1:0]  bc, br, coord_a, coord_b, srow, scol;
  logic [ADDR_W-1:0] li_eff;

  // Register clamping
  always_comb begin
    if (cfg.mag_x == '0)                mx = MAG_CW'(1);
    else if (32'(cfg.mag_x) > MAX_MAG)  mx = MAG_CW'(MAX_MAG);
    else                                mx = MAG_CW'(cfg.mag_x);
    if (cfg.mag_y == '0)                my = MAG_CW'(1);
    else if (32'(cfg.mag_y) > MAX_MAG)  my = MAG_CW'(MAX_MAG);
    else                                my = MAG_CW'(cfg.mag_y);
    if (cfg.src_width == '0)                      sw = SW_W'(1);
    else if (32'(cfg.src_width) > MAX_SRC_WIDTH)  sw = SW_W'(MAX_SRC_WIDTH);
    else                                          sw = SW_W'(cfg.src_width);
    if (cfg.src_height == '0)                     sh = SH_W'(1);
    else if (32'(cfg.src_height) > MAX_SRC_HEIGHT) sh = SH_W'(MAX_SRC_HEIGHT);
    else                                          sh = SH_W'(cfg.src_height);
    if (cfg.view_width == '0)                     vw = VIEW_SW'(1);
    else if (32'(cfg.view_width) > MAX_VIEW)      vw = VIEW_SW'(MAX_VIEW);
    else                                          vw = VIEW_SW'(cfg.view_width);
    if (cfg.view_height == '0)                    vh = VIEW_SW'(1);
    else if (32'(cfg.view_height) > MAX_VIEW)     vh = VIEW_SW'(MAX_VIEW);
    else                                          vh = VIEW_SW'(cfg.view_height);
  end

  // Output frame size, clipped to the view
  always_comb begin
    mirror_lr = cfg.orientation[ORIENT_MIRROR_LR];
    transpose = cfg.orientation[ORIENT_TRANSPOSE];
    // row coordinate mirrors the other way round when transposed
    mirror_b  = cfg.orientation[ORIENT_MIRROR_TB] ^ transpose;
    dim_x     = transpose ? DIM_W'(sh) : DIM_W'(sw);
    dim_y     = transpose ? DIM_W'(sw) : DIM_W'(sh);
    ow_full   = EXT_W'(mx) * EXT_W'(dim_x);
    oh_full   = EXT_W'(my) * EXT_W'(dim_y);
    ow        = (ow_full > EXT_W'(vw)) ? vw : VIEW_SW'(ow_full);
    oh        = (oh_full > EXT_W'(vh)) ? vh : VIEW_SW'(oh_full);
  end

  // Load position
  always_comb begin
    total        = TOT_W'(sw) * TOT_W'(sh);
    li_eff       = (TOT_W'(load_idx_r) >= total) ? '0 : load_idx_r;
    load_inc     = TOT_W'(li_eff) + TOT_W'(1);
    load_addr    = li_eff;
    load_idx_nxt = (load_inc >= total) ? '0 : ADDR_W'(load_inc);
  end

  // Emit position, restarted when it lies outside the current frame
  always_comb begin
    if ((VIEW_SW'(ecol_r) >= ow) || (VIEW_SW'(erow_r) >= oh)) begin
      ec  = '0;
      er  = '0;
      cs  = '0;
      rs  = '0;
      bcl = '0;
      brw = '0;
    end else begin
      ec  = ecol_r;
      er  = erow_r;
      cs  = csub_r;
      rs  = rsub_r;
      bcl = bcol_r;
      brw = brow_r;
    end
  end

  // Source address of the current output pixel
  always_comb begin
    bc      = (DIM_W'(bcl) < dim_x) ? DIM_W'(bcl) : dim_x - DIM_W'(1);
    br      = (DIM_W'(brw) < dim_y) ? DIM_W'(brw) : dim_y - DIM_W'(1);
    coord_a = mirror_lr ? dim_x - DIM_W'(1) - bc : bc;
    coord_b = mirror_b ? dim_y - DIM_W'(1) - br : br;
    srow    = transpose ? coord_a : coord_b;
    scol    = transpose ? coord_b : coord_a;
    rd_addr = ADDR_W'(AW2'(srow) * AW2'(sw) + AW2'(scol));
    pos_x   = ec;
    pos_y   = er;
  end

  // Raster step
  always_comb begin
    ecol_nxt   = ec;
    erow_nxt   = er;
    csub_nxt   = cs;
    rsub_nxt   = rs;
    bcol_nxt   = bcl;
    brow_nxt   = brw;
    frame_last = 1'b0;
    if ((VIEW_SW'(ec) + VIEW_SW'(1)) < ow) begin
      ecol_nxt = ec + POS_W'(1);
      if ((MAG_CW'(cs) + MAG_CW'(1)) >= mx) begin
        csub_nxt = '0;
        bcol_nxt = bcl + BLK_W'(1);
      end else begin
        csub_nxt = cs + SUB_W'(1);
      end
    end else begin
      ecol_nxt = '0;
      csub_nxt = '0;
      bcol_nxt = '0;
      if ((VIEW_SW'(er) + VIEW_SW'(1)) < oh) begin
        erow_nxt = er + POS_W'(1);
        if ((MAG_CW'(rs) + MAG_CW'(1)) >= my) begin
          rsub_nxt = '0;
          brow_nxt = brw + BLK_W'(1);
        end else begin
          rsub_nxt = rs + SUB_W'(1);
        end
      end else begin
        erow_nxt   = '0;
        rsub_nxt   = '0;
        brow_nxt   = '0;
        frame_last = 1'b1;
      end
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      load_idx_r <= '0;
      ecol_r     <= '0;
      erow_r     <= '0;
      csub_r     <= '0;
      rsub_r     <= '0;
      bcol_r     <= '0;
      brow_r     <= '0;
    end else begin
      if (ctrl.load_go) begin
        load_idx_r <= load_idx_nxt;
      end
      if (ctrl.emit_go) begin
        ecol_r <= ecol_nxt;
        erow_r <= erow_nxt;
        csub_r <= csub_nxt;
        rsub_r <= rsub_nxt;
        bcol_r <= bcol_nxt;
        brow_r <= brow_nxt;
      end
    end
  end

endmodule

// ----- rtl/pixel_zoom_flip_rotate_core.sv -----
// ----------------------------------------------------------------------------
// pixel_zoom_flip_rotate_core - nearest-neighbour zoom with mirror/transpose
// Loads a source frame in raster order, then streams the zoomed, mirrored
// and optionally transposed frame one pixel per read word.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      in         in_valid/in_stall    in_opcode, in_pixel_in
//  out_     out        out_valid/out_stall  out_pixel_out, out_x, out_y,
//                                           out_frame_last
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One word is accepted per cycle while in_stall is low; a read word's pixel
// passes through the frame store read and then the output register.
// The single-port frame store read and the address multiply set the pace.
// Reset loads the register defaults and clears the positions and valid flags;
// the frame store is not cleared. in_stall rises only when both the read stage
// and the output register hold a pixel and out_stall is high. Load words write the store at acceptance.
// ----------------------------------------------------------------------------
module pixel_zoom_flip_rotate_core #(
  parameter int MAX_SRC_WIDTH  = pzfr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = pzfr_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_VIEW       = pzfr_pkg::DEF_MAX_VIEW,
  parameter int MAX_MAG        = pzfr_pkg::DEF_MAX_MAG
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [pzfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pzfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [pzfr_pkg::PIX_W-1:0]        in_pixel_in,
  // output words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pzfr_pkg::PIX_W-1:0]        out_pixel_out,
  output logic [pzfr_pkg::COORD_W-1:0]      out_x,
  output logic [pzfr_pkg::COORD_W-1:0]      out_y,
  output logic                              out_frame_last
);
  import pzfr_pkg::*;

  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(MAX_VIEW);

  cfg_t              cfg_r;
  scan_ctrl_t        ctrl;
  logic              cfg_hit;
  logic              in_acc, s1_adv;
  logic [ADDR_W-1:0] load_addr, rd_addr;
  logic [POS_W-1:0]  pos_x, pos_y;
  logic              scan_last;

  // Read stage
  logic              s1_valid_r;
  logic [PIX_W-1:0]  rdata_r;
  logic [POS_W-1:0]  s1_x_r, s1_y_r;
  logic              s1_last_r;

  // Output register
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic              out_last_r;

  // Frame store
  logic [PIX_W-1:0]  frame_mem [DEPTH];

  // Configuration write decode
  always_comb begin
    unique case (cfg_reg_t'(cfg_index))
      REG_MAG_X, REG_MAG_Y, REG_ORIENTATION, REG_SRC_WIDTH,
      REG_SRC_HEIGHT, REG_VIEW_WIDTH, REG_VIEW_HEIGHT: cfg_hit = 1'b1;
      default:                                         cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mag_x       <= RST_MAG_X;
      cfg_r.mag_y       <= RST_MAG_Y;
      cfg_r.orientation <= RST_ORIENTATION;
      cfg_r.src_width   <= RST_SRC_WIDTH;
      cfg_r.src_height  <= RST_SRC_HEIGHT;
      cfg_r.view_width  <= RST_VIEW_WIDTH;
      cfg_r.view_height <= RST_VIEW_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAG_X:       cfg_r.mag_x       <= MAG_W'(cfg_wdata);
        REG_MAG_Y:       cfg_r.mag_y       <= MAG_W'(cfg_wdata);
        REG_ORIENTATION: cfg_r.orientation <= ORIENT_W'(cfg_wdata);
        REG_SRC_WIDTH:   cfg_r.src_width   <= SRC_DIM_W'(cfg_wdata);
        REG_SRC_HEIGHT:  cfg_r.src_height  <= SRC_DIM_W'(cfg_wdata);
        REG_VIEW_WIDTH:  cfg_r.view_width  <= VIEW_DIM_W'(cfg_wdata);
        REG_VIEW_HEIGHT: cfg_r.view_height <= VIEW_DIM_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Handshake: read stage drains into the output register
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    ctrl.restart = cfg_wr_en && cfg_hit;
    ctrl.load_go = in_acc && (in_opcode == OP_LOAD);
    ctrl.emit_go = in_acc && (in_opcode == OP_EMIT);
  end

  pzfr_scan #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_VIEW       (MAX_VIEW),
    .MAX_MAG        (MAX_MAG)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ctrl       (ctrl),
    .load_addr  (load_addr),
    .rd_addr    (rd_addr),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .frame_last (scan_last)
  );

  // Frame store write
  always_ff @(posedge clk) begin
    if (ctrl.load_go) begin
      frame_mem[load_addr] <= in_pixel_in;
    end
  end

  // Frame store read
  always_ff @(posedge clk) begin
    if (ctrl.emit_go) begin
      rdata_r <= frame_mem[rd_addr];
    end
  end

  // Read stage side data
  always_ff @(posedge clk) begin
    if (ctrl.emit_go) begin
      s1_x_r    <= pos_x;
      s1_y_r    <= pos_y;
      s1_last_r <= scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ctrl.emit_go) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r  <= rdata_r;
      out_x_r    <= s1_x_r;
      out_y_r    <= s1_y_r;
      out_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_x          = COORD_W'(out_x_r);
  assign out_y          = COORD_W'(out_y_r);
  assign out_frame_last = out_last_r;

endmodule
